### hw/rtl/casq_pkg.sv
package casq_pkg;

    localparam int QUEUE_DEPTH = 64;

    localparam int IDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SEQ_W      = 32;
    localparam int SIZE_W     = 16;
    localparam int HANDLE_W   = 32;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int BYTE_W     = $clog2(QUEUE_DEPTH * (2 ** SIZE_W - 1) + 1);
    localparam int OUT_CNT_W  = 7;
    localparam int OUT_BYTE_W = 22;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_FLUSH   = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ACK_EMPTY = 2'd1,
        ST_NO_MATCH  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic    capture;
        logic    enq_write;
        logic    flush;
        logic    walk_init;
        logic    walk_read;
        logic    walk_next;
        logic    ack_commit;
        logic    head_read;
        logic    out_load;
        logic    status_we;
        t_status status_code;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    empty;
        logic    full;
        logic    match;
        logic    walk_last;
    } t_dp_sts;

endpackage

### hw/rtl/casq_req_if.sv
interface casq_req_if;
    logic                              valid;
    logic                              ready;
    logic [casq_pkg::ACTION_W-1:0]     action;
    logic [casq_pkg::SEQ_W-1:0]        first_seq;
    logic [casq_pkg::SIZE_W-1:0]       payload_len;
    logic [casq_pkg::HANDLE_W-1:0]     buffer_handle;
    logic [casq_pkg::SEQ_W-1:0]        ack_number;

    modport source (
        output valid, action, first_seq, payload_len, buffer_handle, ack_number,
        input  ready
    );
    modport sink (
        input  valid, action, first_seq, payload_len, buffer_handle, ack_number,
        output ready
    );
endinterface

### hw/rtl/casq_rsp_if.sv
interface casq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [casq_pkg::STATUS_W-1:0]     status;
    logic [casq_pkg::OUT_CNT_W-1:0]    released_count;
    logic [casq_pkg::OUT_CNT_W-1:0]    queued_count;
    logic [casq_pkg::OUT_BYTE_W-1:0]   queued_bytes;
    logic                              queue_empty;
    logic [casq_pkg::SEQ_W-1:0]        head_seq;
    logic [casq_pkg::SIZE_W-1:0]       head_size;
    logic [casq_pkg::HANDLE_W-1:0]     head_handle;

    modport source (
        output valid, status, released_count, queued_count, queued_bytes,
               queue_empty, head_seq, head_size, head_handle,
        input  ready
    );
    modport sink (
        input  valid, status, released_count, queued_count, queued_bytes,
               queue_empty, head_seq, head_size, head_handle,
        output ready
    );
endinterface

### hw/rtl/cumulative_ack_send_queue_unit.sv
// Retransmission queue of sent TCP segments, 64 entries deep. Each request
// enqueues a segment, applies a cumulative ACK or flushes the queue (an unused
// action code changes nothing) and gives exactly one response with the status,
// the number of entries released, the stored segment and byte counts and the
// oldest entry (zero when empty). Requests are handled one at a time: each
// passes through decode and a read of the head; an ACK to a non-empty queue
// walks it from the head, one read and one compare of the single-port entry
// store per entry. A finished response waits in an output register, so the
// next request is taken while it is pending.
module cumulative_ack_send_queue_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    casq_req_if.sink  i_req,
    casq_rsp_if.source o_rsp
);

    casq_pkg::t_dp_cmd cmd;
    casq_pkg::t_dp_sts sts;

    casq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    casq_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_req.action),
        .i_first_seq       (i_req.first_seq),
        .i_payload_len     (i_req.payload_len),
        .i_buffer_handle   (i_req.buffer_handle),
        .i_ack_number      (i_req.ack_number),
        .o_status          (o_rsp.status),
        .o_released_count  (o_rsp.released_count),
        .o_queued_count    (o_rsp.queued_count),
        .o_queued_bytes    (o_rsp.queued_bytes),
        .o_queue_empty     (o_rsp.queue_empty),
        .o_head_seq        (o_rsp.head_seq),
        .o_head_size       (o_rsp.head_size),
        .o_head_handle     (o_rsp.head_handle)
    );

endmodule

### hw/rtl/casq_datapath.sv
module casq_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  casq_pkg::t_dp_cmd                  i_cmd,
    output casq_pkg::t_dp_sts                  o_sts,
    input  logic [casq_pkg::ACTION_W-1:0]      i_action,
    input  logic [casq_pkg::SEQ_W-1:0]         i_first_seq,
    input  logic [casq_pkg::SIZE_W-1:0]        i_payload_len,
    input  logic [casq_pkg::HANDLE_W-1:0]      i_buffer_handle,
    input  logic [casq_pkg::SEQ_W-1:0]         i_ack_number,
    output logic [casq_pkg::STATUS_W-1:0]      o_status,
    output logic [casq_pkg::OUT_CNT_W-1:0]     o_released_count,
    output logic [casq_pkg::OUT_CNT_W-1:0]     o_queued_count,
    output logic [casq_pkg::OUT_BYTE_W-1:0]    o_queued_bytes,
    output logic                               o_queue_empty,
    output logic [casq_pkg::SEQ_W-1:0]         o_head_seq,
    output logic [casq_pkg::SIZE_W-1:0]        o_head_size,
    output logic [casq_pkg::HANDLE_W-1:0]      o_head_handle
);

    localparam int IDX_W  = casq_pkg::IDX_W;
    localparam int CNT_W  = casq_pkg::CNT_W;
    localparam int BYTE_W = casq_pkg::BYTE_W;
    localparam int SEQ_W  = casq_pkg::SEQ_W;
    localparam int DEPTH  = casq_pkg::QUEUE_DEPTH;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    casq_pkg::t_entry  r_mem [DEPTH];
    casq_pkg::t_entry  r_rd;
    logic [IDX_W-1:0]  rd_addr;

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_bytes;

    casq_pkg::t_action             r_action;
    logic [casq_pkg::SEQ_W-1:0]    r_seq;
    logic [casq_pkg::SIZE_W-1:0]   r_size;
    logic [casq_pkg::HANDLE_W-1:0] r_handle;
    logic [casq_pkg::SEQ_W-1:0]    r_ack;

    logic [IDX_W-1:0]  r_walk_idx;
    logic [IDX_W-1:0]  r_walk_k;
    logic [BYTE_W-1:0] r_walk_sum;

    casq_pkg::t_status r_status;
    logic [CNT_W-1:0]  r_released;

    logic [CNT_W-1:0]  walk_hits;
    logic              empty;

    assign walk_hits = CNT_W'(r_walk_k) + 1'b1;
    assign empty     = (r_count == '0);
    assign rd_addr   = i_cmd.walk_read ? r_walk_idx : r_head;

    assign o_sts.action    = r_action;
    assign o_sts.empty     = empty;
    assign o_sts.full      = (r_count >= CNT_W'(DEPTH));
    assign o_sts.match     = ((r_rd.seq + SEQ_W'(r_rd.size)) == r_ack);
    assign o_sts.walk_last = (walk_hits == r_count);

    // entry store
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_write) begin
            r_mem[r_tail] <= '{seq: r_seq, size: r_size, handle: r_handle};
        end
        if (i_cmd.walk_read || i_cmd.head_read) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_bytes <= '0;
        end else begin
            if (i_cmd.enq_write) begin
                r_tail  <= next_slot(r_tail);
                r_count <= r_count + 1'b1;
                r_bytes <= r_bytes + BYTE_W'(r_size);
            end
            if (i_cmd.flush) begin
                r_head  <= r_tail;
                r_count <= '0;
                r_bytes <= '0;
            end
            if (i_cmd.ack_commit) begin
                r_head  <= next_slot(r_walk_idx);
                r_count <= r_count - walk_hits;
                r_bytes <= r_bytes - (r_walk_sum + BYTE_W'(r_rd.size));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= casq_pkg::t_action'(i_action);
            r_seq      <= i_first_seq;
            r_size     <= i_payload_len;
            r_handle   <= i_buffer_handle;
            r_ack      <= i_ack_number;
            r_status   <= casq_pkg::ST_OK;
            r_released <= '0;
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.flush) begin
            r_released <= r_count;
        end
        if (i_cmd.ack_commit) begin
            r_released <= walk_hits;
        end
        if (i_cmd.walk_init) begin
            r_walk_idx <= r_head;
            r_walk_k   <= '0;
            r_walk_sum <= '0;
        end
        if (i_cmd.walk_next) begin
            r_walk_idx <= next_slot(r_walk_idx);
            r_walk_k   <= r_walk_k + 1'b1;
            r_walk_sum <= r_walk_sum + BYTE_W'(r_rd.size);
        end
        if (i_cmd.out_load) begin
            o_status          <= r_status;
            o_released_count  <= casq_pkg::OUT_CNT_W'(r_released);
            o_queued_count    <= casq_pkg::OUT_CNT_W'(r_count);
            o_queued_bytes    <= casq_pkg::OUT_BYTE_W'(r_bytes);
            o_queue_empty     <= empty;
            o_head_seq        <= empty ? '0 : r_rd.seq;
            o_head_size       <= empty ? '0 : r_rd.size;
            o_head_handle     <= empty ? '0 : r_rd.handle;
        end
    end

endmodule

### hw/rtl/casq_ctrl.sv
module casq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    input  casq_pkg::t_dp_sts  i_sts,
    output casq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DECODE    = 6'b000010,
        S_ACK_RD    = 6'b000100,
        S_ACK_CMP   = 6'b001000,
        S_HEAD_RD   = 6'b010000,
        S_HEAD_WAIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   slot_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign slot_free   = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status_code = casq_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_HEAD_RD;
                unique case (i_sts.action)
                    casq_pkg::ACT_ENQUEUE: begin
                        if (i_sts.full) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = casq_pkg::ST_FULL;
                        end else begin
                            o_cmd.enq_write = 1'b1;
                        end
                    end
                    casq_pkg::ACT_ACK: begin
                        if (i_sts.empty) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = casq_pkg::ST_ACK_EMPTY;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state = S_ACK_RD;
                        end
                    end
                    casq_pkg::ACT_FLUSH: begin
                        o_cmd.flush = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_ACK_RD: begin
                o_cmd.walk_read = 1'b1;
                n_state = S_ACK_CMP;
            end
            S_ACK_CMP: begin
                priority if (i_sts.match) begin
                    o_cmd.ack_commit = 1'b1;
                    n_state = S_HEAD_RD;
                end else if (i_sts.walk_last) begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = casq_pkg::ST_NO_MATCH;
                    n_state = S_HEAD_RD;
                end else begin
                    o_cmd.walk_next = 1'b1;
                    n_state = S_ACK_RD;
                end
            end
            S_HEAD_RD: begin
                o_cmd.head_read = 1'b1;
                n_state = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_rsp_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

### tb/sv/casq_report_checker.sv
module casq_report_checker
    import casq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    casq_req_if  i_req,
    casq_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status               status;
        logic [OUT_CNT_W-1:0]  released;
        logic [OUT_CNT_W-1:0]  segments;
        logic [OUT_BYTE_W-1:0] bytes;
        logic                  empty;
        logic [SEQ_W-1:0]      head_seq;
        logic [SIZE_W-1:0]     head_size;
        logic [HANDLE_W-1:0]   head_handle;
    } queue_report_t;

    logic [SEQ_W-1:0]    slot_seq    [QUEUE_DEPTH];
    logic [SIZE_W-1:0]   slot_size   [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] slot_handle [QUEUE_DEPTH];
    int unsigned         head_ptr;
    int unsigned         tail_ptr;
    int unsigned         held_segments;
    longint unsigned     held_bytes;
    queue_report_t       reports_due[$];
    int                  mismatches = 0;
    int                  response_index = 0;

    function automatic int unsigned wrap_next(int unsigned idx);
        return (idx + 1 >= QUEUE_DEPTH) ? 0 : idx + 1;
    endfunction

    task automatic release_oldest();
        held_bytes    -= slot_size[head_ptr];
        held_segments -= 1;
        head_ptr       = wrap_next(head_ptr);
    endtask

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("mismatch on response %0d, %s: got 0x%0h, expected 0x%0h",
                 response_index, field, got, want);
    endtask

    // Applies the accepted request to the shadow queue and builds its response.
    task automatic predict_report(output queue_report_t rep);
        int unsigned      idx;
        int unsigned      hits;
        int unsigned      k;
        logic [SEQ_W-1:0] end_seq;
        rep        = '0;
        rep.status = ST_OK;
        case (i_req.action)
            ACT_ENQUEUE: begin
                if (held_segments >= QUEUE_DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    slot_seq[tail_ptr]    = i_req.first_seq;
                    slot_size[tail_ptr]   = i_req.payload_len;
                    slot_handle[tail_ptr] = i_req.buffer_handle;
                    tail_ptr              = wrap_next(tail_ptr);
                    held_segments        += 1;
                    held_bytes           += i_req.payload_len;
                end
            end
            ACT_ACK: begin
                if (held_segments == 0) begin
                    rep.status = ST_ACK_EMPTY;
                end else begin
                    idx  = head_ptr;
                    hits = 0;
                    for (k = 0; k < held_segments && hits == 0; k++) begin
                        end_seq = slot_seq[idx] + {{(SEQ_W-SIZE_W){1'b0}}, slot_size[idx]};
                        if (end_seq == i_req.ack_number)
                            hits = k + 1;
                        idx = wrap_next(idx);
                    end
                    if (hits == 0) begin
                        rep.status = ST_NO_MATCH;
                    end else begin
                        repeat (hits) release_oldest();
                        rep.released = OUT_CNT_W'(hits);
                    end
                end
            end
            ACT_FLUSH: begin
                rep.released = OUT_CNT_W'(held_segments);
                while (held_segments != 0)
                    release_oldest();
            end
            default: ;
        endcase
        rep.segments = OUT_CNT_W'(held_segments);
        rep.bytes    = OUT_BYTE_W'(held_bytes);
        rep.empty    = (held_segments == 0);
        if (held_segments != 0) begin
            rep.head_seq    = slot_seq[head_ptr];
            rep.head_size   = slot_size[head_ptr];
            rep.head_handle = slot_handle[head_ptr];
        end
    endtask

    always @(posedge i_clk) begin : watch
        queue_report_t want;
        if (!i_rst_n) begin
            head_ptr      = 0;
            tail_ptr      = 0;
            held_segments = 0;
            held_bytes    = 0;
            reports_due.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (reports_due.size() == 0) begin
                    report_mismatch("response with no request outstanding", 0, 0);
                end else begin
                    want = reports_due.pop_front();
                    if (i_rsp.status != want.status)
                        report_mismatch("status", i_rsp.status, want.status);
                    if (i_rsp.released_count != want.released)
                        report_mismatch("released_count", i_rsp.released_count, want.released);
                    if (i_rsp.queued_count != want.segments)
                        report_mismatch("queued_count", i_rsp.queued_count, want.segments);
                    if (i_rsp.queued_bytes != want.bytes)
                        report_mismatch("queued_bytes", i_rsp.queued_bytes, want.bytes);
                    if (i_rsp.queue_empty != want.empty)
                        report_mismatch("queue_empty", i_rsp.queue_empty, want.empty);
                    if (i_rsp.head_seq != want.head_seq)
                        report_mismatch("head_seq", i_rsp.head_seq, want.head_seq);
                    if (i_rsp.head_size != want.head_size)
                        report_mismatch("head_size", i_rsp.head_size, want.head_size);
                    if (i_rsp.head_handle != want.head_handle)
                        report_mismatch("head_handle", i_rsp.head_handle, want.head_handle);
                end
                response_index++;
            end
            if (i_req.valid && i_req.ready) begin
                predict_report(want);
                reports_due.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= reports_due.size();
    end

endmodule

### tb/sv/tb_cumulative_ack_send_queue_unit.sv
module tb_cumulative_ack_send_queue_unit;
    import casq_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int SETTLE_CYCLES   = 150;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    int               fail_count;
    int               reports_pending;
    int unsigned      idle_cycles = 0;
    bit               steady_run = 1'b0;
    bit               hold_request = 1'b0;
    logic [SEQ_W-1:0] open_ends[$];
    logic [SEQ_W-1:0] next_seq = '0;

    casq_req_if req_bus();
    casq_rsp_if rsp_bus();

    cumulative_ack_send_queue_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    casq_report_checker u_report_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (reports_pending)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_seg_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return '0;
        if (r < 75)
            return SIZE_W'($urandom_range(1, 1460));
        if (r < 92)
            return SIZE_W'($urandom_range(1, 65535));
        return '1;
    endfunction

    function automatic int pick_ack_index();
        int unsigned r;
        int          n;
        r = $urandom_range(0, 99);
        n = open_ends.size();
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(0, (n > 4) ? 3 : n - 1);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic send_request(logic [ACTION_W-1:0] act, logic [SEQ_W-1:0] seq,
                                logic [SIZE_W-1:0] seg_len, logic [HANDLE_W-1:0] handle,
                                logic [SEQ_W-1:0] ack);
        int unsigned gap;
        gap = pick_idle_len();
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.action        <= act;
        req_bus.first_seq     <= seq;
        req_bus.payload_len   <= seg_len;
        req_bus.buffer_handle <= handle;
        req_bus.ack_number    <= ack;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // open_ends tracks end sequence numbers held by the block, used to aim ACKs.
    task automatic send_enqueue(logic [SEQ_W-1:0] seq, logic [SIZE_W-1:0] seg_len,
                                logic [HANDLE_W-1:0] handle);
        send_request(ACT_ENQUEUE, seq, seg_len, handle, $urandom());
        if (open_ends.size() < QUEUE_DEPTH)
            open_ends.push_back(seq + {{(SEQ_W-SIZE_W){1'b0}}, seg_len});
    endtask

    task automatic send_ack(logic [SEQ_W-1:0] ack);
        int hit;
        int i;
        send_request(ACT_ACK, $urandom(), SIZE_W'($urandom()), $urandom(), ack);
        hit = -1;
        for (i = 0; i < open_ends.size() && hit < 0; i++)
            if (open_ends[i] == ack)
                hit = i;
        repeat (hit + 1) void'(open_ends.pop_front());
    endtask

    task automatic send_flush();
        send_request(ACT_FLUSH, $urandom(), SIZE_W'($urandom()), $urandom(), $urandom());
        open_ends.delete();
    endtask

    task automatic send_unused();
        send_request(ACT_UNUSED, $urandom(), SIZE_W'($urandom()), $urandom(), $urandom());
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (reports_pending != 0) @(posedge i_clk);
    endtask

    // Response side: random stalls, one long hold-off when asked.
    initial begin : rsp_drive
        int unsigned gap;
        bit          hold_done;
        hold_done = 1'b0;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                gap = pick_idle_len();
                if (gap != 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                rsp_bus.ready <= 1'b1;
                do @(posedge i_clk); while (!rsp_bus.valid);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int               n;
        int unsigned      r;
        logic [SEQ_W-1:0] base;
        logic [SIZE_W-1:0] seg_len;

        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.action        <= '0;
        req_bus.first_seq     <= '0;
        req_bus.payload_len   <= '0;
        req_bus.buffer_handle <= '0;
        req_bus.ack_number    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_ack('0);
        send_flush();
        send_unused();
        send_enqueue(32'hFFFF_FFFF, 16'd1, 32'h0);       // end wraps to zero
        send_enqueue(32'h0, 16'hFFFF, 32'hFFFF_FFFF);
        send_enqueue(32'hFFFF_0000, 16'd0, 32'h1);       // zero-length segment
        send_enqueue(32'h10, 16'h10, 32'h2);
        send_enqueue(32'h18, 16'h8, 32'h3);              // same end as previous
        send_ack(32'h0012_3456);                         // no match
        send_ack(32'h0);
        send_unused();
        send_ack(32'h20);                                // nearest of two matches
        send_ack(32'h20);
        send_ack(32'hFFFF_FFFF);
        send_enqueue(32'hA5A5_5A5A, 16'h8000, 32'h5A5A_A5A5);
        send_flush();
        wait_for_drain();

        // Fill to full and past it with max-size segments, responses held off at first.
        hold_request = 1'b1;
        base = $urandom();
        for (n = 0; n < QUEUE_DEPTH + 3; n++)
            send_enqueue(base + SEQ_W'(n) * 32'hFFFF, 16'hFFFF, $urandom());
        send_ack(base - 1);
        send_ack(base + SEQ_W'(QUEUE_DEPTH) * 32'hFFFF);
        for (n = 0; n < 5; n++)
            send_enqueue($urandom(), pick_seg_len(), $urandom());
        send_flush();
        wait_for_drain();

        next_seq = $urandom();
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0)
                steady_run = ($urandom_range(0, 3) == 0);
            if (n % 300 == 150)
                wait_for_drain();
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 80 && open_ends.size() == 0)) begin
                if (open_ends.size() == 0 && $urandom_range(0, 3) == 0)
                    next_seq = $urandom();
                seg_len = pick_seg_len();
                send_enqueue(next_seq, seg_len, $urandom());
                next_seq += {{(SEQ_W-SIZE_W){1'b0}}, seg_len};
            end else if (r < 80) begin
                send_ack(open_ends[pick_ack_index()]);
            end else if (r < 88) begin
                send_ack($urandom());
            end else if (r < 92) begin
                send_ack((open_ends.size() != 0) ? open_ends[0] - 1 : $urandom());
            end else if (r < 95) begin
                send_flush();
            end else if (r < 97) begin
                send_unused();
            end else begin
                send_enqueue($urandom(), pick_seg_len(), $urandom());   // out of order
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && reports_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### cumulative_ack_send_queue_unit.f
hw/rtl/casq_pkg.sv
hw/rtl/casq_req_if.sv
hw/rtl/casq_rsp_if.sv
hw/rtl/casq_datapath.sv
hw/rtl/casq_ctrl.sv
hw/rtl/cumulative_ack_send_queue_unit.sv
tb/sv/casq_report_checker.sv
tb/sv/tb_cumulative_ack_send_queue_unit.sv
